### rtl/core/sccd_pkg.sv
`timescale 1ns / 1ps
package sccd_pkg;
	localparam int SETS_DEF = 256;
	localparam int WAYS_DEF = 4;
	localparam int BLOCK_BYTES_DEF = 64;

	localparam logic [2:0] OP_PRRD = 3'd0;
	localparam logic [2:0] OP_PRWR = 3'd1;
	localparam logic [2:0] OP_BUSRD = 3'd2;
	localparam logic [2:0] OP_BUSRDX = 3'd3;
	localparam logic [2:0] OP_BUSUPGR = 3'd4;
	localparam logic [2:0] OP_BUSUPD = 3'd5;

	localparam logic [2:0] ST_I = 3'd0;
	localparam logic [2:0] ST_S = 3'd1;
	localparam logic [2:0] ST_E = 3'd2;
	localparam logic [2:0] ST_M = 3'd3;
	localparam logic [2:0] ST_DE = 3'd4;
	localparam logic [2:0] ST_SC = 3'd5;
	localparam logic [2:0] ST_SM = 3'd6;
	localparam logic [2:0] ST_DM = 3'd7;

	localparam logic [1:0] MODE_MSI = 2'd0;
	localparam logic [1:0] MODE_MESI = 2'd1;
	localparam logic [1:0] MODE_DRAGON = 2'd2;

	localparam logic [0:0] REG_PROTOCOL_MODE = 1'd0;

	typedef enum logic [0:0] {PH_IDLE, PH_UPDATE} phase_t;

	typedef struct packed {
		logic hit;
		logic [2:0] prior_state;
		logic writeback;
		logic snoop_shared;
		logic intervened;
		logic invalidated;
		logic flushed;
		logic extra_mem_txn;
	} result_t;

	typedef struct packed {
		logic [2:0] next_state;
		logic shared;
		logic writeback;
		logic intervened;
		logic invalidated;
		logic flushed;
		logic extra;
	} snoop_t;

	function automatic snoop_t snoop_next(input logic [2:0] op, input logic [1:0] mode,
			input logic [2:0] st);
		snoop_t r;
		r = '0;
		r.next_state = st;
		case (op)
			OP_BUSRD: begin
				case (mode)
					MODE_MSI: begin
						if (st == ST_M) begin
							r.next_state = ST_S; r.writeback = 1'b1;
							r.intervened = 1'b1; r.flushed = 1'b1;
						end
					end
					MODE_MESI: begin
						if (st == ST_S) r.shared = 1'b1;
						else if (st == ST_E) begin
							r.next_state = ST_S; r.intervened = 1'b1; r.shared = 1'b1;
						end else if (st == ST_M) begin
							r.next_state = ST_S; r.writeback = 1'b1; r.flushed = 1'b1;
							r.intervened = 1'b1; r.shared = 1'b1;
						end
					end
					MODE_DRAGON: begin
						if (st == ST_DE) begin
							r.next_state = ST_SC; r.intervened = 1'b1; r.shared = 1'b1;
						end else if (st == ST_SC) r.shared = 1'b1;
						else if (st == ST_SM) begin
							r.writeback = 1'b1; r.flushed = 1'b1; r.shared = 1'b1;
						end else if (st == ST_DM) begin
							r.next_state = ST_SM; r.writeback = 1'b1; r.intervened = 1'b1;
							r.extra = 1'b1; r.flushed = 1'b1; r.shared = 1'b1;
						end
					end
					default: ;
				endcase
			end
			OP_BUSRDX: begin
				case (mode)
					MODE_MSI: begin
						if (st == ST_S) begin
							r.next_state = ST_I; r.invalidated = 1'b1;
						end else if (st == ST_M) begin
							r.next_state = ST_I; r.writeback = 1'b1;
							r.invalidated = 1'b1; r.flushed = 1'b1;
						end
					end
					MODE_MESI: begin
						if (st == ST_S || st == ST_E) begin
							r.next_state = ST_I; r.invalidated = 1'b1; r.shared = 1'b1;
						end else if (st == ST_M) begin
							r.next_state = ST_I; r.writeback = 1'b1; r.flushed = 1'b1;
							r.invalidated = 1'b1; r.shared = 1'b1;
						end
					end
					default: ;
				endcase
			end
			OP_BUSUPGR: begin
				if (mode == MODE_MESI && st == ST_S) begin
					r.next_state = ST_I; r.invalidated = 1'b1;
				end
			end
			OP_BUSUPD: begin
				if (st == ST_S) r.shared = 1'b1;
				else if (mode == MODE_DRAGON) begin
					if (st == ST_SC) r.shared = 1'b1;
					else if (st == ST_SM) begin
						r.next_state = ST_SC; r.shared = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction
endpackage

### rtl/core/snooping_coherent_cache_directory.sv
`timescale 1ns / 1ps
// Channel   | signals                                   | handshake
// request   | op, address, new_state                    | start && !busy
// result    | hit, prior_state, writeback, snoop_shared,| done, one cycle
//           | intervened, invalidated, flushed,         |
//           | extra_mem_txn                             |
// config    | psel, penable, pwrite, paddr, pwdata      | APB, pready high
// For each item the set row (tags, states, stamps of all ways)
// is read from one memory at the accepting edge, then updated and written
// back in the following cycle, the only cycle in which busy is high.
// done pulses in the cycle after the write-back, while the next item may be
// accepted. After arst_n every row reads as all ways invalid; the tag and
// stamp memory needs no clearing. The result side cannot stall.
module snooping_coherent_cache_directory #(
	parameter int SETS = sccd_pkg::SETS_DEF,
	parameter int WAYS = sccd_pkg::WAYS_DEF,
	parameter int BLOCK_BYTES = sccd_pkg::BLOCK_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] op,
	input logic [31:0] address,
	input logic [2:0] new_state,
	output logic done,
	output logic hit,
	output logic [2:0] prior_state,
	output logic writeback,
	output logic snoop_shared,
	output logic intervened,
	output logic invalidated,
	output logic flushed,
	output logic extra_mem_txn,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [0:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int OFFB = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int SETB = $clog2(SETS + 1) - 1;
	localparam int AW = SETB > 0 ? SETB : 1;
	localparam int TAGW = 32 - OFFB - SETB;
	localparam int WAYW = WAYS > 1 ? $clog2(WAYS) : 1;
	localparam int ENTW = TAGW + 3 + 32;
	localparam int ROWW = ENTW * WAYS;

	typedef struct packed {
		logic [TAGW-1:0] tag;
		logic [2:0] st;
		logic [31:0] stamp;
	} entry_t;

	sccd_pkg::phase_t phase_q, phase_next;
	logic [1:0] mode_q;
	logic [31:0] clock_q;
	logic [2:0] op_s1;
	logic [TAGW-1:0] tag_s1;
	logic [AW-1:0] set_s1;
	logic [2:0] ns_s1;
	sccd_pkg::result_t res_q, res_d;
	logic done_q;

	logic [AW-1:0] set_in;
	logic [ROWW-1:0] row_rd, row_wr;
	logic row_ok;
	logic accept, do_write;

	assign accept = start && !busy;
	assign set_in = SETB > 0 ? AW'(address >> OFFB) : '0;

	sccd_ram #(.WIDTH(ROWW), .DEPTH(SETS)) u_rows (
		.clk(clk), .we(do_write), .waddr(set_s1), .wdata(row_wr),
		.raddr(set_in), .rdata(row_rd)
	);

	sccd_valid #(.SETS(SETS), .AW(AW)) u_valid (
		.clk(clk), .arst_n(arst_n), .set_row(do_write), .waddr(set_s1),
		.raddr(set_in), .rvalid(row_ok)
	);

	always_comb begin
		case (phase_q)
			sccd_pkg::PH_IDLE: phase_next = accept ? sccd_pkg::PH_UPDATE : sccd_pkg::PH_IDLE;
			sccd_pkg::PH_UPDATE: phase_next = sccd_pkg::PH_IDLE;
			default: phase_next = sccd_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		case (phase_q)
			sccd_pkg::PH_UPDATE: busy = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	// Update of the set row read in the previous cycle.
	logic [31:0] clk_next;
	entry_t ent [WAYS];
	entry_t ent_new [WAYS];
	logic found, have_inv;
	logic [WAYW-1:0] hway, iway, lway, vway;
	logic [31:0] least;
	sccd_pkg::snoop_t sn;
	logic is_proc;

	always_comb begin
		is_proc = op_s1 == sccd_pkg::OP_PRRD || op_s1 == sccd_pkg::OP_PRWR;
		clk_next = clock_q + 32'd1;
		found = 1'b0; hway = '0; have_inv = 1'b0; iway = '0;
		lway = '0; least = clk_next;
		for (int w = 0; w < WAYS; w++) begin
			ent[w] = row_rd[w*ENTW +: ENTW];
			if (!row_ok) ent[w].st = sccd_pkg::ST_I;
			ent_new[w] = ent[w];
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!found && ent[w].st != sccd_pkg::ST_I && ent[w].tag == tag_s1) begin
				found = 1'b1; hway = WAYW'(w);
			end
			if (!have_inv && ent[w].st == sccd_pkg::ST_I) begin
				have_inv = 1'b1; iway = WAYW'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (ent[w].stamp <= least) begin
				least = ent[w].stamp; lway = WAYW'(w);
			end
		end
		vway = found ? hway : (have_inv ? iway : lway);
		sn = sccd_pkg::snoop_next(op_s1, mode_q, ent[hway].st);
		res_d = '0;
		res_d.hit = found;
		res_d.prior_state = found ? ent[hway].st : sccd_pkg::ST_I;
		if (is_proc) begin
			if (!found) begin
				res_d.writeback = ent[vway].st == sccd_pkg::ST_M ||
					ent[vway].st == sccd_pkg::ST_SM || ent[vway].st == sccd_pkg::ST_DM;
				ent_new[vway].tag = tag_s1;
			end
			ent_new[vway].stamp = clk_next;
			ent_new[vway].st = ns_s1;
		end else if (found && op_s1 <= sccd_pkg::OP_BUSUPD) begin
			res_d.writeback = sn.writeback;
			res_d.snoop_shared = sn.shared;
			res_d.intervened = sn.intervened;
			res_d.invalidated = sn.invalidated;
			res_d.flushed = sn.flushed;
			res_d.extra_mem_txn = sn.extra;
			ent_new[hway].st = sn.next_state;
		end else if (!found) begin
			res_d.prior_state = sccd_pkg::ST_I;
		end
		if (op_s1 > sccd_pkg::OP_BUSUPD) res_d = '0;
		for (int w = 0; w < WAYS; w++) row_wr[w*ENTW +: ENTW] = ent_new[w];
	end

	// Rows are only written by processor accesses or snoop hits, so a fresh row
	// always gets all its ways defined from the invalid-masked view.
	assign do_write = phase_q == sccd_pkg::PH_UPDATE &&
		(is_proc || (found && op_s1 <= sccd_pkg::OP_BUSUPD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sccd_pkg::PH_IDLE;
			mode_q <= sccd_pkg::MODE_MSI;
			clock_q <= '0;
			done_q <= 1'b0;
		end else begin
			phase_q <= phase_next;
			done_q <= phase_q == sccd_pkg::PH_UPDATE;
			if (phase_q == sccd_pkg::PH_UPDATE && is_proc) clock_q <= clk_next;
			if (psel && penable && pwrite && paddr == sccd_pkg::REG_PROTOCOL_MODE)
				mode_q <= pwdata[1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			tag_s1 <= TAGW'(address >> (OFFB + SETB));
			set_s1 <= set_in;
			ns_s1 <= new_state;
		end
		if (phase_q == sccd_pkg::PH_UPDATE) res_q <= res_d;
	end

	assign done = done_q;
	assign hit = res_q.hit;
	assign prior_state = res_q.prior_state;
	assign writeback = res_q.writeback;
	assign snoop_shared = res_q.snoop_shared;
	assign intervened = res_q.intervened;
	assign invalidated = res_q.invalidated;
	assign flushed = res_q.flushed;
	assign extra_mem_txn = res_q.extra_mem_txn;
	assign pready = 1'b1;
	assign prdata = paddr == sccd_pkg::REG_PROTOCOL_MODE ? {30'd0, mode_q} : 32'd0;
endmodule

### rtl/core/sccd_ram.sv
`timescale 1ns / 1ps
module sccd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/sccd_valid.sv
`timescale 1ns / 1ps
// Per-row validity flags: a row never written reads as all ways invalid.
module sccd_valid #(
	parameter int SETS = 256,
	parameter int AW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic set_row,
	input logic [AW-1:0] waddr,
	input logic [AW-1:0] raddr,
	output logic rvalid
);
	logic [SETS-1:0] row_valid_q;
	logic rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (set_row) row_valid_q[waddr] <= 1'b1;
			rvalid_q <= row_valid_q[raddr];
		end
	end

	assign rvalid = rvalid_q;
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	logic clk, arst_n;
	logic start, busy, done;
	logic [2:0] op, new_state;
	logic [31:0] address;
	logic hit, writeback, snoop_shared, intervened, invalidated, flushed, extra_mem_txn;
	logic [2:0] prior_state;
	logic psel, penable, pwrite;
	logic [0:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	snooping_coherent_cache_directory DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.address(address), .new_state(new_state), .done(done), .hit(hit),
		.prior_state(prior_state), .writeback(writeback), .snoop_shared(snoop_shared),
		.intervened(intervened), .invalidated(invalidated), .flushed(flushed),
		.extra_mem_txn(extra_mem_txn), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the directory.
	logic [17:0] sh_tag[1024];
	logic [2:0] sh_state[1024];
	logic [31:0] sh_stamp[1024];
	logic [31:0] sh_clock;
	logic [1:0] sh_mode;

	sccd_pkg::result_t expected_q[$];
	bit typed_on;
	sccd_pkg::result_t typed_val;
	int errors;
	int quiet_cycles;
	int idle_pct;

	typedef struct {
		logic [2:0] o;
		logic [31:0] a;
		logic [2:0] s;
		bit ty;
		sccd_pkg::result_t r;
	} row_t;
	row_t plan[$];

	function automatic sccd_pkg::result_t directory_step(input logic [2:0] o,
			input logic [31:0] a, input logic [2:0] s);
		sccd_pkg::result_t r;
		int base, slot, w;
		logic [31:0] least;
		logic [2:0] st;
		r = '0;
		base = a[13:6] * 4;
		slot = -1;
		if (o > sccd_pkg::OP_BUSUPD)
			return r;
		if (o == sccd_pkg::OP_PRRD || o == sccd_pkg::OP_PRWR)
			sh_clock = sh_clock + 1;
		for (w = 0; w < 4; w++)
			if (slot < 0 && sh_state[base + w] != sccd_pkg::ST_I &&
					sh_tag[base + w] == a[31:14])
				slot = base + w;
		if (o == sccd_pkg::OP_PRRD || o == sccd_pkg::OP_PRWR) begin
			if (slot >= 0) begin
				r.hit = 1'b1;
				r.prior_state = sh_state[slot];
			end else begin
				for (w = 3; w >= 0; w--)
					if (sh_state[base + w] == sccd_pkg::ST_I)
						slot = base + w;
				if (slot < 0) begin
					// Oldest stamp wins; later ways win ties.
					slot = base;
					least = sh_clock;
					for (w = 0; w < 4; w++)
						if (sh_stamp[base + w] <= least) begin
							slot = base + w;
							least = sh_stamp[base + w];
						end
				end
				st = sh_state[slot];
				r.writeback = (st == sccd_pkg::ST_M || st == sccd_pkg::ST_SM ||
					st == sccd_pkg::ST_DM);
				sh_tag[slot] = a[31:14];
			end
			sh_stamp[slot] = sh_clock;
			sh_state[slot] = s;
			return r;
		end
		if (slot < 0)
			return r;
		st = sh_state[slot];
		r.hit = 1'b1;
		r.prior_state = st;
		case (o)
			sccd_pkg::OP_BUSRD: begin
				if (sh_mode == sccd_pkg::MODE_MSI && st == sccd_pkg::ST_M) begin
					sh_state[slot] = sccd_pkg::ST_S;
					{r.writeback, r.intervened, r.flushed} = 3'b111;
				end else if (sh_mode == sccd_pkg::MODE_MESI) begin
					r.snoop_shared = (st == sccd_pkg::ST_S || st == sccd_pkg::ST_E ||
						st == sccd_pkg::ST_M);
					if (st == sccd_pkg::ST_E) begin
						sh_state[slot] = sccd_pkg::ST_S;
						r.intervened = 1'b1;
					end else if (st == sccd_pkg::ST_M) begin
						sh_state[slot] = sccd_pkg::ST_S;
						{r.writeback, r.intervened, r.flushed} = 3'b111;
					end
				end else if (sh_mode == sccd_pkg::MODE_DRAGON) begin
					r.snoop_shared = (st >= sccd_pkg::ST_DE);
					if (st == sccd_pkg::ST_DE) begin
						sh_state[slot] = sccd_pkg::ST_SC;
						r.intervened = 1'b1;
					end else if (st == sccd_pkg::ST_SM) begin
						{r.writeback, r.flushed} = 2'b11;
					end else if (st == sccd_pkg::ST_DM) begin
						sh_state[slot] = sccd_pkg::ST_SM;
						{r.writeback, r.intervened, r.flushed, r.extra_mem_txn} = 4'b1111;
					end
				end
			end
			sccd_pkg::OP_BUSRDX: begin
				if (sh_mode == sccd_pkg::MODE_MSI || sh_mode == sccd_pkg::MODE_MESI) begin
					if (st == sccd_pkg::ST_S || st == sccd_pkg::ST_M ||
							(sh_mode == sccd_pkg::MODE_MESI && st == sccd_pkg::ST_E)) begin
						sh_state[slot] = sccd_pkg::ST_I;
						r.invalidated = 1'b1;
						r.snoop_shared = (sh_mode == sccd_pkg::MODE_MESI);
						if (st == sccd_pkg::ST_M)
							{r.writeback, r.flushed} = 2'b11;
					end
				end
			end
			sccd_pkg::OP_BUSUPGR: begin
				if (sh_mode == sccd_pkg::MODE_MESI && st == sccd_pkg::ST_S) begin
					sh_state[slot] = sccd_pkg::ST_I;
					r.invalidated = 1'b1;
				end
			end
			default: begin
				if (st == sccd_pkg::ST_S)
					r.snoop_shared = 1'b1;
				else if (sh_mode == sccd_pkg::MODE_DRAGON &&
						(st == sccd_pkg::ST_SC || st == sccd_pkg::ST_SM)) begin
					r.snoop_shared = 1'b1;
					sh_state[slot] = sccd_pkg::ST_SC;
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : watch
		sccd_pkg::result_t p, e;
		if (arst_n) begin
			quiet_cycles++;
			if (start && !busy) begin
				quiet_cycles = 0;
				p = directory_step(op, address, new_state);
				expected_q.push_back(typed_on ? typed_val : p);
			end
			if (done) begin
				quiet_cycles = 0;
				if (expected_q.size() == 0) begin
					$display("%0t: result with no item outstanding", $time);
					errors++;
				end else begin
					e = expected_q.pop_front();
					check_field("hit", e.hit, hit);
					check_field("prior_state", e.prior_state, prior_state);
					check_field("writeback", e.writeback, writeback);
					check_field("snoop_shared", e.snoop_shared, snoop_shared);
					check_field("intervened", e.intervened, intervened);
					check_field("invalidated", e.invalidated, invalidated);
					check_field("flushed", e.flushed, flushed);
					check_field("extra_mem_txn", e.extra_mem_txn, extra_mem_txn);
				end
			end
			if (psel && penable && pwrite)
				quiet_cycles = 0;
			if (quiet_cycles >= 3000) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic send_item(input logic [2:0] o, input logic [31:0] a, input logic [2:0] s,
			input bit ty, input sccd_pkg::result_t tv);
		start <= 1'b1;
		op <= o;
		address <= a;
		new_state <= s;
		typed_on <= ty;
		typed_val <= tv;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_mode(input logic [1:0] m);
		start <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= sccd_pkg::REG_PROTOCOL_MODE;
		pwdata <= {30'($urandom_range(0, 32'h3fff_ffff)), m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sh_mode = m;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void add_row(input logic [2:0] o, input logic [31:0] a,
			input logic [2:0] s, input bit ty, input sccd_pkg::result_t r);
		row_t x;
		x.o = o;
		x.a = a;
		x.s = s;
		x.ty = ty;
		x.r = r;
		plan.push_back(x);
	endfunction

	function automatic logic [2:0] pick_state(input logic [1:0] m);
		logic [2:0] msi_st[2], mesi_st[3];
		msi_st = '{sccd_pkg::ST_S, sccd_pkg::ST_M};
		mesi_st = '{sccd_pkg::ST_S, sccd_pkg::ST_E, sccd_pkg::ST_M};
		if ($urandom_range(9) < 4)
			return 3'($urandom_range(7));
		case (m)
			sccd_pkg::MODE_MSI: return msi_st[$urandom_range(1)];
			sccd_pkg::MODE_MESI: return mesi_st[$urandom_range(2)];
			default: return 3'($urandom_range(sccd_pkg::ST_DE, sccd_pkg::ST_DM));
		endcase
	endfunction

	initial begin
		logic [17:0] tag_pool[8];
		logic [1:0] modes[6];
		logic [2:0] o;
		logic [31:0] a;
		int k, n, ph;
		errors = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = sccd_pkg::OP_PRRD;
		address = '0;
		new_state = sccd_pkg::ST_I;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		typed_on = 1'b0;
		typed_val = '0;
		sh_clock = '0;
		sh_mode = sccd_pkg::MODE_MSI;
		for (k = 0; k < 1024; k++) begin
			sh_tag[k] = '0;
			sh_state[k] = sccd_pkg::ST_I;
			sh_stamp[k] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under MSI, the mode after reset.
		add_row(sccd_pkg::OP_PRRD, 32'h0, sccd_pkg::ST_S, 1, '0);
		add_row(sccd_pkg::OP_PRWR, 32'h0, sccd_pkg::ST_M, 1, {1'b1, sccd_pkg::ST_S, 6'b0});
		add_row(sccd_pkg::OP_BUSRD, 32'h0, sccd_pkg::ST_I, 1,
			{1'b1, sccd_pkg::ST_M, 6'b101010});
		add_row(sccd_pkg::OP_BUSRDX, 32'h3f, sccd_pkg::ST_I, 1,
			{1'b1, sccd_pkg::ST_S, 6'b000100});
		add_row(sccd_pkg::OP_BUSRD, 32'h0, sccd_pkg::ST_I, 1, '0);
		add_row(3'd6, 32'hffff_ffff, sccd_pkg::ST_DM, 1, '0);
		add_row(3'd7, 32'hffff_ffff, sccd_pkg::ST_DM, 1, '0);
		add_row(sccd_pkg::OP_PRWR, 32'hffff_ffff, sccd_pkg::ST_DM, 1, '0);
		add_row(sccd_pkg::OP_BUSUPD, 32'hffff_ffc0, sccd_pkg::ST_I, 0, '0);
		add_row(sccd_pkg::OP_BUSUPGR, 32'hffff_ffff, sccd_pkg::ST_I, 0, '0);
		for (k = 1; k <= 5; k++)
			add_row(sccd_pkg::OP_PRWR, k << 14, sccd_pkg::ST_M, 0, '0);
		add_row(sccd_pkg::OP_PRRD, 32'h4000, sccd_pkg::ST_S, 0, '0);
		add_row(sccd_pkg::OP_BUSUPD, 32'h8000, sccd_pkg::ST_I, 0, '0);
		add_row(sccd_pkg::OP_BUSRDX, 32'hc000, sccd_pkg::ST_I, 0, '0);
		add_row(sccd_pkg::OP_PRWR, 32'h1_4000, sccd_pkg::ST_S, 0, '0);
		add_row(sccd_pkg::OP_BUSUPD, 32'h1_4000, sccd_pkg::ST_I, 0, '0);
		foreach (plan[i])
			send_item(plan[i].o, plan[i].a, plan[i].s, plan[i].ty, plan[i].r);

		// Random part: each phase picks a mode and a sender idling level.
		modes = '{sccd_pkg::MODE_MESI, sccd_pkg::MODE_DRAGON, 2'd3, sccd_pkg::MODE_MSI,
			sccd_pkg::MODE_DRAGON, sccd_pkg::MODE_MESI};
		for (ph = 0; ph < 6; ph++) begin
			write_mode(modes[ph]);
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 45;
				default: idle_pct = 13;
			endcase
			for (k = 0; k < 8; k++)
				tag_pool[k] = 18'($urandom);
			for (n = 0; n < 72; n++) begin
				k = $urandom_range(99);
				if (k < 45)
					o = 3'($urandom_range(sccd_pkg::OP_PRRD, sccd_pkg::OP_PRWR));
				else if (k < 95)
					o = 3'($urandom_range(sccd_pkg::OP_BUSRD, sccd_pkg::OP_BUSUPD));
				else
					o = 3'($urandom_range(6, 7));
				if ($urandom_range(9) == 0)
					a = $urandom;
				else
					a = {tag_pool[$urandom_range(7)], 6'b0, 2'($urandom_range(3)),
						6'($urandom)};
				send_item(o, a, pick_state(sh_mode), 0, '0);
			end
		end
		start <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule

### files.f
rtl/core/sccd_pkg.sv
rtl/core/sccd_ram.sv
rtl/core/sccd_valid.sv
rtl/core/snooping_coherent_cache_directory.sv
tb/tb_top.sv
